// ===== hdl/boids_pkg.sv =====
// ----------------------------------------------------------------------------
// Boids step package
// Shared codes, register indexes, types and the sequencer state encoding.
// ----------------------------------------------------------------------------
package boids_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_FIELD_W   = 3'd0,
    REG_FIELD_H   = 3'd1,
    REG_MAX_SPEED = 3'd2,
    REG_MAX_FORCE = 3'd3,
    REG_ALIGN_R   = 3'd4,
    REG_SEP_R     = 3'd5,
    REG_COH_R     = 3'd6,
    REG_ACTIVE    = 3'd7
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_SELF,
    ST_SELF,
    ST_NB_RD,
    ST_NB_LOAD,
    ST_NB_TEST,
    ST_SEP_DIVX,
    ST_SEP_DIVY,
    ST_NB_NEXT,
    ST_STEER_AVG,
    ST_STEER_OFF,
    ST_SCALE_SQ,
    ST_SCALE_DIV,
    ST_SUB_VEL,
    ST_LIM_CHK,
    ST_LIM_DIV,
    ST_ACC,
    ST_EDGE,
    ST_VEL_CHK,
    ST_VEL_DIV,
    ST_WB,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    SQ_A = 2'd0,
    SQ_B = 2'd1,
    SQ_C = 2'd2,
    SQ_V = 2'd3
  } stage_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hdl/boids_div.sv =====
// ----------------------------------------------------------------------------
// Boids divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module boids_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [63:0]       num_i,
  input  logic        [63:0]       den_i,
  output boids_pkg::unit_ctl_t     ctl_o,
  output logic signed [63:0]       quo_o
);
  import boids_pkg::*;

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;
  logic [63:0] rsh;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rsh    = {rem_q[62:0], quo_q[63]};
    trial  = {1'b0, rsh} - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i[63] ? 64'(-num_i) : num_i;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[63];
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rsh;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign quo_o = neg_q ? 64'(-quo_q) : quo_q;
  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};

  busy_count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 7'd0) else $error("divider busy with zero count");
  done_after_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  start_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider failed to start");

endmodule

// ===== hdl/boids_flocking_step_unit.sv =====
// ----------------------------------------------------------------------------
// Boids flocking step unit
// Stores boids in on-chip memories and steps one boid against its neighbors.
// ----------------------------------------------------------------------------
// Input channel: valid_i/stall_o with action, entry index and a boid payload.
// Output channel: out_valid_o/out_stall_i, one transaction per write, step
// or read; action 3 gives none. Config: cfg_valid_i/cfg_ready_o, index, data.
// A write passes through the writeback and output states; a read first fetches
// the entry from the store. A step scans the active entries as neighbors, runs
// a pair of separation divides per neighbor that falls inside the separation
// radius, then works the three steering terms and the velocity limit: each term
// runs two averaging divides, and up to two square roots each followed by a
// pair of scaling divides. All of these share the single divider and square
// root unit.
// One item is worked at a time; stall_o is high from acceptance until the
// result has moved into the output register. The output register holds
// while out_stall_i is high, and the next item may be accepted meanwhile.
// Reset returns registers to their defaults; store contents are undefined
// until written.
// ----------------------------------------------------------------------------
module boids_flocking_step_unit #(
  parameter int unsigned MAX_BOIDS = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [1:0]         action_i,
  input  logic [5:0]         entry_index_i,
  input  logic signed [31:0] in_pos_x_i,
  input  logic signed [31:0] in_pos_y_i,
  input  logic signed [31:0] in_vel_x_i,
  input  logic signed [31:0] in_vel_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         out_index_o,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import boids_pkg::*;

  localparam int unsigned AW = (MAX_BOIDS > 1) ? $clog2(MAX_BOIDS) : 1;
  localparam int unsigned CW = $clog2(MAX_BOIDS + 1);
  localparam int unsigned SH = FRAC_BITS - 8;

  // configuration
  logic [15:0] fw_q, fh_q;
  logic [30:0] mspd_q, mfrc_q;
  logic [11:0] ra_q, rs_q, rc_q;
  logic [6:0]  act_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= 16'd1024;
      fh_q   <= 16'd768;
      mspd_q <= 31'd131072;
      mfrc_q <= 31'd6554;
      ra_q   <= 12'd10;
      rs_q   <= 12'd250;
      rc_q   <= 12'd200;
      act_q  <= 7'd64;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FIELD_W:   fw_q   <= cfg_data_i[15:0];
        REG_FIELD_H:   fh_q   <= cfg_data_i[15:0];
        REG_MAX_SPEED: mspd_q <= cfg_data_i[30:0];
        REG_MAX_FORCE: mfrc_q <= cfg_data_i[30:0];
        REG_ALIGN_R:   ra_q   <= cfg_data_i[11:0];
        REG_SEP_R:     rs_q   <= cfg_data_i[11:0];
        REG_COH_R:     rc_q   <= cfg_data_i[11:0];
        REG_ACTIVE:    act_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // memories: position and velocity, one read and one write port each
  logic [63:0] pos_mem [MAX_BOIDS];
  logic [63:0] vel_mem [MAX_BOIDS];
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [63:0]   wr_pos, wr_vel, rd_pos_q, rd_vel_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      vel_mem[wr_addr] <= wr_vel;
    end
    rd_pos_q <= pos_mem[rd_addr];
    rd_vel_q <= vel_mem[rd_addr];
  end

  // shared divider
  logic               div_start;
  logic signed [63:0] div_num, div_quo;
  logic [63:0]        div_den;
  unit_ctl_t          div_ctl;

  boids_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .ctl_o   (div_ctl),
    .quo_o   (div_quo)
  );

  // state
  state_e st_q, st_d;
  stage_e stg_q, stg_d;
  logic [1:0]    act_kind_q;
  logic [AW-1:0] idx_q, j_q;
  logic [CW-1:0] jn_q, nlim_q;
  logic signed [31:0] px_q, py_q, vx_q, vy_q, ox_q, oy_q, ovx_q, ovy_q;
  logic signed [63:0] sax_q, say_q, scx_q, scy_q, ssx_q, ssy_q;
  logic [CW-1:0] na_q, nc_q, ns_q;
  logic signed [33:0] dx_q, dy_q;
  logic [63:0]  d2s_q;
  logic signed [31:0] wx_q, wy_q;
  logic signed [33:0] accx_q, accy_q;
  logic [30:0]  len_q;
  logic [63:0]  m_q;
  logic         ydiv_q, lim_q;
  logic [63:0]  sq_v_q, sq_r_q, sq_b_q;
  logic         sq_busy_q;
  logic [5:0]   out_idx_q;
  logic signed [31:0] opx_q, opy_q, ovxo_q, ovyo_q;
  logic         out_v_q;
  logic         sel_q;

  // neighbor test combinational; only the in-radius range of q matters
  logic [33:0] adx, ady;
  logic [19:0] qx, qy;
  logic [39:0] qx2, qy2;
  logic [23:0] ra2, rs2, rc2;
  logic [63:0] d2;
  logic        same, in_a, in_s, in_c;
  always_comb begin
    adx  = dx_q[33] ? 34'(-dx_q) : 34'(dx_q);
    ady  = dy_q[33] ? 34'(-dy_q) : 34'(dy_q);
    qx   = 20'(adx >> SH);
    qy   = 20'(ady >> SH);
    qx2  = qx * qx;
    qy2  = qy * qy;
    d2   = 64'(qx2) + 64'(qy2);
    ra2  = ra_q * ra_q;
    rs2  = rs_q * rs_q;
    rc2  = rc_q * rc_q;
    same = (dx_q == '0) && (dy_q == '0);
    in_a = (adx < (34'(ra_q) << FRAC_BITS)) && (ady < (34'(ra_q) << FRAC_BITS)) &&
           (d2 < (64'(ra2) << 16));
    in_s = (adx < (34'(rs_q) << FRAC_BITS)) && (ady < (34'(rs_q) << FRAC_BITS)) &&
           (d2 < (64'(rs2) << 16));
    in_c = (adx < (34'(rc_q) << FRAC_BITS)) && (ady < (34'(rc_q) << FRAC_BITS)) &&
           (d2 < (64'(rc2) << 16));
  end

  // squared length of working vector
  logic [31:0] awx, awy;
  logic [63:0] wx2, wy2, wl2, frc2, spd2;
  assign awx  = wx_q[31] ? 32'(-wx_q) : 32'(wx_q);
  assign awy  = wy_q[31] ? 32'(-wy_q) : 32'(wy_q);
  assign wx2  = awx * awx;
  assign wy2  = awy * awy;
  assign wl2  = wx2 + wy2;
  assign frc2 = mfrc_q * mfrc_q;
  assign spd2 = mspd_q * mspd_q;

  // scaling products
  logic signed [63:0] mul_x, mul_y;
  assign mul_x = wx_q * $signed({1'b0, len_q});
  assign mul_y = wy_q * $signed({1'b0, len_q});

  // steering source selection
  logic signed [63:0] sum_x, sum_y;
  logic [CW-1:0]      cnt_s;
  always_comb begin
    case (stg_q)
      SQ_A: begin sum_x = sax_q; sum_y = say_q; cnt_s = na_q; end
      SQ_B: begin sum_x = scx_q; sum_y = scy_q; cnt_s = nc_q; end
      SQ_C: begin sum_x = ssx_q; sum_y = ssy_q; cnt_s = ns_q; end
      default: begin sum_x = '0; sum_y = '0; cnt_s = '0; end
    endcase
  end

  logic in_acc, out_acc;
  assign in_acc  = valid_i && !stall_o;
  assign out_acc = out_v_q && !out_stall_i;
  assign stall_o = (st_q != ST_IDLE);

  // square root unit: two radicand bits per cycle
  logic        sq_start;
  logic [63:0] sq_in;
  logic        sq_done;
  logic [63:0] sq_t;
  assign sq_done = !sq_busy_q;
  assign sq_t    = sq_r_q + sq_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_busy_q <= 1'b0;
    else if (sq_start) sq_busy_q <= 1'b1;
    else if (sq_busy_q && sq_b_q == '0) sq_busy_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (sq_start) begin
      sq_v_q <= sq_in;
      sq_r_q <= '0;
      sq_b_q <= 64'h4000_0000_0000_0000;
    end else if (sq_busy_q && sq_b_q != '0) begin
      if (sq_v_q >= sq_t) begin
        sq_v_q <= sq_v_q - sq_t;
        sq_r_q <= (sq_r_q >> 1) + sq_b_q;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_b_q <= sq_b_q >> 2;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:      if (in_acc) begin
                      if (action_e'(action_i) == ACT_NONE) st_d = ST_IDLE;
                      else if (action_e'(action_i) == ACT_WRITE) st_d = ST_WB;
                      else st_d = ST_RD_SELF;
                    end
      ST_RD_SELF:   st_d = ST_SELF;
      ST_SELF:      st_d = (action_e'(act_kind_q) == ACT_READ) ? ST_OUT :
                           (nlim_q == '0) ? ST_STEER_AVG : ST_NB_RD;
      ST_NB_RD:     st_d = ST_NB_LOAD;
      ST_NB_LOAD:   st_d = ST_NB_TEST;
      ST_NB_TEST:   st_d = (!same && in_s) ? ST_SEP_DIVX : ST_NB_NEXT;
      ST_SEP_DIVX:  if (div_ctl.done) st_d = ST_SEP_DIVY;
      ST_SEP_DIVY:  if (div_ctl.done) st_d = ST_NB_NEXT;
      ST_NB_NEXT:   st_d = (jn_q == nlim_q) ? ST_STEER_AVG : ST_NB_RD;
      ST_STEER_AVG: st_d = (cnt_s == '0) ? ST_ACC :
                           (div_ctl.done && ydiv_q) ? ST_STEER_OFF : ST_STEER_AVG;
      ST_STEER_OFF: st_d = ST_SCALE_SQ;
      ST_SCALE_SQ:  if (sq_done && !sq_start) st_d = (sq_r_q == '0) ? ST_SUB_VEL :
                                                ST_SCALE_DIV;
      ST_SCALE_DIV: if (div_ctl.done && ydiv_q)
                      st_d = (stg_q == SQ_V) ? ST_WB : lim_q ? ST_ACC : ST_SUB_VEL;
      ST_SUB_VEL:   st_d = ST_LIM_CHK;
      ST_LIM_CHK:   st_d = (wl2 > frc2) ? ST_SCALE_SQ : ST_ACC;
      ST_ACC:       st_d = (stg_q == SQ_C) ? ST_EDGE : ST_STEER_AVG;
      ST_EDGE:      st_d = ST_VEL_CHK;
      ST_VEL_CHK:   st_d = (wl2 > spd2) ? ST_SCALE_SQ : ST_WB;
      ST_WB:        st_d = ST_OUT;
      ST_OUT:       if (!out_v_q || out_acc) st_d = ST_IDLE;
      default:      st_d = ST_IDLE;
    endcase
  end

  // datapath and control outputs
  logic signed [65:0] t1, t2;
  always_comb begin
    rd_addr   = idx_q;
    wr_en     = (st_q == ST_WB);
    wr_addr   = idx_q;
    wr_pos    = {py_q, px_q};
    wr_vel    = {vy_q, vx_q};
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 64'd1;
    sq_start  = 1'b0;
    sq_in     = wl2;
    t1        = 66'(accx_q);
    t2        = 66'(accy_q);
    if (px_q < 0) t1 = t1 + (66'sd1 <<< FRAC_BITS);
    else if (66'(px_q) > (66'(fw_q) <<< FRAC_BITS)) t1 = t1 - (66'sd1 <<< FRAC_BITS);
    if (py_q < 0) t2 = t2 + (66'sd1 <<< FRAC_BITS);
    else if (66'(py_q) > (66'(fh_q) <<< FRAC_BITS)) t2 = t2 - (66'sd1 <<< FRAC_BITS);
    case (st_q)
      ST_RD_SELF: rd_addr = idx_q;
      ST_NB_RD:   rd_addr = j_q;
      ST_NB_TEST: if (!same && in_s) begin
                    div_start = 1'b1;
                    div_num   = 64'(dx_q) <<< 16;
                    div_den   = (d2 == '0) ? 64'd1 : d2;
                  end
      ST_SEP_DIVX: if (div_ctl.done) begin
                     div_start = 1'b1;
                     div_num   = 64'(dy_q) <<< 16;
                     div_den   = d2s_q;
                   end
      ST_STEER_AVG: if (cnt_s != '0 && !div_ctl.busy && !div_ctl.done && !sel_q) begin
                      div_start = 1'b1;
                      div_num   = sum_x;
                      div_den   = 64'(cnt_s);
                    end else if (div_ctl.done && !ydiv_q) begin
                      div_start = 1'b1;
                      div_num   = sum_y;
                      div_den   = 64'(cnt_s);
                    end
      ST_SCALE_SQ: if (!sq_busy_q && !sel_q) sq_start = 1'b1;
                   else if (sq_done && sq_r_q != '0) begin
                     div_start = 1'b1;
                     div_num   = mul_x;
                     div_den   = sq_r_q;
                   end
      ST_SCALE_DIV: if (div_ctl.done && !ydiv_q) begin
                      div_start = 1'b1;
                      div_num   = mul_y;
                      div_den   = m_q;
                    end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      out_v_q <= 1'b0;
      sel_q   <= 1'b0;
      ydiv_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_OUT && (!out_v_q || out_acc)) out_v_q <= 1'b1;
      else if (out_acc) out_v_q <= 1'b0;
      case (st_q)
        ST_STEER_AVG: begin
          if (st_d != ST_STEER_AVG) begin
            sel_q  <= 1'b0;
            ydiv_q <= 1'b0;
          end else begin
            if (div_start) sel_q <= 1'b1;
            if (div_ctl.done) ydiv_q <= !ydiv_q;
          end
        end
        ST_SCALE_SQ:  sel_q  <= (st_d == ST_SCALE_SQ) && (sel_q || sq_start);
        ST_SCALE_DIV: ydiv_q <= (st_d == ST_SCALE_DIV) && (ydiv_q ^ div_ctl.done);
        default: begin sel_q <= 1'b0; ydiv_q <= 1'b0; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: if (in_acc) begin
        act_kind_q <= action_i;
        idx_q      <= AW'(entry_index_i);
        px_q <= in_pos_x_i; py_q <= in_pos_y_i;
        vx_q <= in_vel_x_i; vy_q <= in_vel_y_i;
        nlim_q <= (32'(act_q) > MAX_BOIDS) ? CW'(MAX_BOIDS) : CW'(act_q);
        j_q  <= '0; jn_q <= '0;
        sax_q <= '0; say_q <= '0; scx_q <= '0; scy_q <= '0;
        ssx_q <= '0; ssy_q <= '0;
        na_q <= '0; nc_q <= '0; ns_q <= '0;
        stg_q <= SQ_A; accx_q <= '0; accy_q <= '0; lim_q <= 1'b0;
      end
      ST_SELF: begin
        px_q <= rd_pos_q[31:0];  py_q <= rd_pos_q[63:32];
        vx_q <= rd_vel_q[31:0];  vy_q <= rd_vel_q[63:32];
      end
      ST_NB_LOAD: begin
        dx_q  <= 34'(px_q) - 34'($signed(rd_pos_q[31:0]));
        dy_q  <= 34'(py_q) - 34'($signed(rd_pos_q[63:32]));
        ox_q  <= rd_pos_q[31:0];  oy_q  <= rd_pos_q[63:32];
        ovx_q <= rd_vel_q[31:0];  ovy_q <= rd_vel_q[63:32];
      end
      ST_NB_TEST: begin
        jn_q <= jn_q + CW'(1);
        j_q  <= j_q + AW'(1);
        d2s_q <= (d2 == '0) ? 64'd1 : d2;
        if (!same) begin
          if (in_a) begin
            sax_q <= sax_q + 64'(ovx_q); say_q <= say_q + 64'(ovy_q);
            na_q <= na_q + CW'(1);
          end
          if (in_c) begin
            scx_q <= scx_q + 64'(ox_q); scy_q <= scy_q + 64'(oy_q);
            nc_q <= nc_q + CW'(1);
          end
          if (in_s) ns_q <= ns_q + CW'(1);
        end
      end
      ST_SEP_DIVX: if (div_ctl.done) ssx_q <= ssx_q + div_quo;
      ST_SEP_DIVY: if (div_ctl.done) ssy_q <= ssy_q + div_quo;
      ST_STEER_AVG: begin
        len_q <= mspd_q; lim_q <= 1'b0;
        if (cnt_s == '0) begin wx_q <= '0; wy_q <= '0; end
        else if (div_ctl.done) begin
          if (!ydiv_q) wx_q <= sat32(66'(div_quo));
          else wy_q <= sat32(66'(div_quo));
        end
      end
      ST_STEER_OFF: if (stg_q == SQ_B) begin
        wx_q <= sat32(66'(wx_q) - 66'(px_q));
        wy_q <= sat32(66'(wy_q) - 66'(py_q));
      end
      ST_SCALE_SQ: if (sq_done && !sq_start) begin
        m_q <= sq_r_q;
        if (sq_r_q == '0) begin wx_q <= '0; wy_q <= '0; end
      end
      ST_SCALE_DIV: if (div_ctl.done) begin
        if (!ydiv_q) begin
          ox_q <= sat32(66'(div_quo));
        end else begin
          wx_q <= ox_q;
          wy_q <= sat32(66'(div_quo));
          if (stg_q == SQ_V) begin vx_q <= ox_q; vy_q <= sat32(66'(div_quo)); end
        end
      end
      ST_SUB_VEL: begin
        wx_q <= sat32(66'(wx_q) - 66'(vx_q));
        wy_q <= sat32(66'(wy_q) - 66'(vy_q));
      end
      ST_LIM_CHK: begin len_q <= mfrc_q; lim_q <= 1'b1; end
      ST_ACC: begin
        accx_q <= accx_q + 34'(wx_q);
        accy_q <= accy_q + 34'(wy_q);
        stg_q  <= stage_e'(stg_q + 2'd1);
      end
      ST_EDGE: begin
        px_q <= sat32(66'(px_q) + 66'(vx_q));
        py_q <= sat32(66'(py_q) + 66'(vy_q));
        wx_q <= sat32(66'(vx_q) + 66'(sat32(t1)));
        wy_q <= sat32(66'(vy_q) + 66'(sat32(t2)));
        vx_q <= sat32(66'(vx_q) + 66'(sat32(t1)));
        vy_q <= sat32(66'(vy_q) + 66'(sat32(t2)));
        len_q <= mspd_q;
        stg_q <= SQ_V;
      end
      ST_OUT: if (!out_v_q || out_acc) begin
        out_idx_q <= 6'(idx_q);
        opx_q <= px_q; opy_q <= py_q; ovxo_q <= vx_q; ovyo_q <= vy_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_v_q;
  assign out_index_o = out_idx_q;
  assign out_pos_x_o = opx_q;
  assign out_pos_y_o = opy_q;
  assign out_vel_x_o = ovxo_q;
  assign out_vel_y_o = ovyo_q;

  out_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stall_i |=> out_v_q) else $error("result dropped");
  idle_stall_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> stall_o || (action_e'($past(action_i)) == ACT_NONE))
    else $error("accepted item not held");
  wb_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> st_q == ST_WB) else $error("stray memory write");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boids flocking step unit testbench
// A directed table, then randomized phases under several register settings.
// Each transaction is checked against an in-bench boid store and step model.
// Both ports idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import boids_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } boid_t;

  typedef struct {
    action_e            act;
    logic [5:0]         idx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    bit                 typed;
    boid_t              want;
  } dir_row_t;

  localparam longint PX       = 65536;
  localparam longint S_MAX    = 64'sd2147483647;
  localparam longint S_MIN    = -64'sd2147483648;
  localparam u64_t   FAR_D2   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int     LIMIT    = 60000;
  localparam int     HOLD_LEN = 3000;

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  logic [1:0]         action_i;
  logic [5:0]         entry_index_i;
  logic signed [31:0] in_pos_x_i;
  logic signed [31:0] in_pos_y_i;
  logic signed [31:0] in_vel_x_i;
  logic signed [31:0] in_vel_y_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [5:0]         out_index_o;
  logic signed [31:0] out_pos_x_o;
  logic signed [31:0] out_pos_y_o;
  logic signed [31:0] out_vel_x_o;
  logic signed [31:0] out_vel_y_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  boids_flocking_step_unit u_dut (.*);

  u64_t               cfg_reg[8];
  logic signed [31:0] st_px[64];
  logic signed [31:0] st_py[64];
  logic signed [31:0] st_vx[64];
  logic signed [31:0] st_vy[64];
  boid_t              pending[$];
  int                 errors;
  int                 idle_cycles;
  int                 burst_left;
  bit                 hold_req;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------- step model ----------------
  function automatic longint sat(longint v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  function automatic u64_t mag(longint v);
    return v < 0 ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic u64_t root(u64_t v);
    u64_t r;
    u64_t b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic u64_t sqlen(longint x, longint y);
    u64_t ax;
    u64_t ay;
    ax = mag(x);
    ay = mag(y);
    return ax * ax + ay * ay;
  endfunction

  task automatic scale_to(inout longint x, inout longint y, input u64_t l);
    u64_t m;
    m = root(sqlen(x, y));
    if (m == 0) begin
      x = 0;
      y = 0;
    end else begin
      x = sat(x * longint'(l) / longint'(m));
      y = sat(y * longint'(l) / longint'(m));
    end
  endtask

  task automatic limit_to(inout longint x, inout longint y, input u64_t l);
    if (sqlen(x, y) > l * l) scale_to(x, y, l);
  endtask

  function automatic u64_t near_d2(u64_t adx, u64_t ady, u64_t r);
    u64_t lim;
    u64_t qx;
    u64_t qy;
    u64_t d2;
    lim = r << 16;
    if (adx >= lim || ady >= lim) return FAR_D2;
    qx = adx >> 8;
    qy = ady >> 8;
    d2 = qx * qx + qy * qy;
    return (d2 < ((r * r) << 16)) ? d2 : FAR_D2;
  endfunction

  task automatic steer(input longint sx, input longint sy, input longint cnt,
                       input longint offx, input longint offy,
                       input longint vx, input longint vy,
                       output longint ox, output longint oy);
    longint x;
    longint y;
    if (cnt == 0) begin
      ox = 0;
      oy = 0;
    end else begin
      x = sat(sx / cnt - offx);
      y = sat(sy / cnt - offy);
      scale_to(x, y, cfg_reg[REG_MAX_SPEED]);
      x = sat(x - vx);
      y = sat(y - vy);
      limit_to(x, y, cfg_reg[REG_MAX_FORCE]);
      ox = x;
      oy = y;
    end
  endtask

  task automatic boid_update(input action_e act, input logic [5:0] idx,
                             input logic signed [31:0] ipx, input logic signed [31:0] ipy,
                             input logic signed [31:0] ivx, input logic signed [31:0] ivy,
                             output bit has, output boid_t res);
    longint px, py, vx, vy, ax, ay, cx, cy, sx, sy, na, nc, ns;
    longint tx, ty, accx, accy, dx, dy, ox, oy;
    u64_t adx, ady, d2;
    int n;
    has = (act != ACT_NONE);
    if (act == ACT_WRITE) begin
      st_px[idx] = ipx;
      st_py[idx] = ipy;
      st_vx[idx] = ivx;
      st_vy[idx] = ivy;
    end else if (act == ACT_STEP) begin
      ax = 0; ay = 0; cx = 0; cy = 0; sx = 0; sy = 0; na = 0; nc = 0; ns = 0;
      n = cfg_reg[REG_ACTIVE] > 64 ? 64 : int'(cfg_reg[REG_ACTIVE]);
      px = st_px[idx];
      py = st_py[idx];
      vx = st_vx[idx];
      vy = st_vy[idx];
      for (int j = 0; j < n; j++) begin
        ox = st_px[j];
        oy = st_py[j];
        dx = px - ox;
        dy = py - oy;
        adx = mag(dx);
        ady = mag(dy);
        if (dx == 0 && dy == 0) continue;
        if (near_d2(adx, ady, cfg_reg[REG_ALIGN_R]) != FAR_D2) begin
          ax += st_vx[j];
          ay += st_vy[j];
          na++;
        end
        d2 = near_d2(adx, ady, cfg_reg[REG_SEP_R]);
        if (d2 != FAR_D2) begin
          if (d2 == 0) d2 = 1;
          sx += dx * 65536 / longint'(d2);
          sy += dy * 65536 / longint'(d2);
          ns++;
        end
        if (near_d2(adx, ady, cfg_reg[REG_COH_R]) != FAR_D2) begin
          cx += ox;
          cy += oy;
          nc++;
        end
      end
      steer(ax, ay, na, 0, 0, vx, vy, tx, ty);
      accx = tx;
      accy = ty;
      steer(cx, cy, nc, px, py, vx, vy, tx, ty);
      accx += tx;
      accy += ty;
      steer(sx, sy, ns, 0, 0, vx, vy, tx, ty);
      accx += tx;
      accy += ty;
      if (px < 0) accx += PX;
      else if (px > longint'(cfg_reg[REG_FIELD_W]) * PX) accx -= PX;
      if (py < 0) accy += PX;
      else if (py > longint'(cfg_reg[REG_FIELD_H]) * PX) accy -= PX;
      accx = sat(accx);
      accy = sat(accy);
      px = sat(px + vx);
      py = sat(py + vy);
      vx = sat(vx + accx);
      vy = sat(vy + accy);
      limit_to(vx, vy, cfg_reg[REG_MAX_SPEED]);
      st_px[idx] = px[31:0];
      st_py[idx] = py[31:0];
      st_vx[idx] = vx[31:0];
      st_vy[idx] = vy[31:0];
    end
    res.idx = idx;
    res.px  = st_px[idx];
    res.py  = st_py[idx];
    res.vx  = st_vx[idx];
    res.vy  = st_vy[idx];
  endtask

  function automatic u64_t reg_mask(int i);
    case (reg_idx_e'(i))
      REG_FIELD_W, REG_FIELD_H:        return 64'hFFFF;
      REG_MAX_SPEED, REG_MAX_FORCE:    return 64'h7FFF_FFFF;
      REG_ALIGN_R, REG_SEP_R, REG_COH_R: return 64'hFFF;
      default:                         return 64'h7F;
    endcase
  endfunction

  // ---------------- checking ----------------
  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    boid_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending.size() == 0) begin
        report("unexpected transaction, index", out_index_o, 0);
      end else begin
        w = pending.pop_front();
        if (out_index_o !== w.idx) report("out_index", out_index_o, w.idx);
        if (out_pos_x_o !== w.px) report("out_pos_x", out_pos_x_o, w.px);
        if (out_pos_y_o !== w.py) report("out_pos_y", out_pos_y_o, w.py);
        if (out_vel_x_o !== w.vx) report("out_vel_x", out_vel_x_o, w.vx);
        if (out_vel_y_o !== w.vy) report("out_vel_y", out_vel_y_o, w.vy);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------- receiver ----------------
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 400);
        end
        mode_left--;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // ---------------- sender ----------------
  task automatic send(input action_e act, input logic [5:0] idx,
                      input logic signed [31:0] px, input logic signed [31:0] py,
                      input logic signed [31:0] vx, input logic signed [31:0] vy,
                      input bit typed, input boid_t want);
    int gap;
    bit has;
    boid_t res;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    valid_i       <= 1'b1;
    action_i      <= act;
    entry_index_i <= idx;
    in_pos_x_i    <= px;
    in_pos_y_i    <= py;
    in_vel_x_i    <= vx;
    in_vel_y_i    <= vy;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    boid_update(act, idx, px, py, vx, vy, has, res);
    if (has) pending.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  task automatic settle();
    valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_regs(input u64_t vals[8]);
    u64_t data;
    for (int i = 0; i < 8; i++) begin
      data = ({32'd0, $urandom} & ~reg_mask(i)) | (vals[i] & reg_mask(i));
      data = data & 64'hFFFF_FFFF;
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx_e'(i);
      cfg_data_i  <= data[31:0];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      cfg_reg[i] = data & reg_mask(i);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic rand_boid(output logic signed [31:0] px, output logic signed [31:0] py,
                           output logic signed [31:0] vx, output logic signed [31:0] vy);
    if ($urandom_range(0, 6) == 0) begin
      px = $urandom;
      py = $urandom;
      vx = $urandom;
      vy = $urandom;
    end else begin
      px = $urandom_range(0, 450 * 65536) - 50 * 65536;
      py = $urandom_range(0, 450 * 65536) - 50 * 65536;
      vx = $urandom_range(0, 6 * 65536) - 3 * 65536;
      vy = $urandom_range(0, 6 * 65536) - 3 * 65536;
    end
  endtask

  function automatic dir_row_t row(action_e act, logic [5:0] idx,
                                   longint px, longint py, longint vx, longint vy,
                                   bit typed);
    dir_row_t r;
    r.act = act;
    r.idx = idx;
    r.px = px[31:0];
    r.py = py[31:0];
    r.vx = vx[31:0];
    r.vy = vy[31:0];
    r.typed = typed;
    r.want.idx = idx;
    r.want.px = px[31:0];
    r.want.py = py[31:0];
    r.want.vx = vx[31:0];
    r.want.vy = vy[31:0];
    return r;
  endfunction

  initial begin
    dir_row_t tab[$];
    u64_t vals[8];
    boid_t none;
    logic signed [31:0] px, py, vx, vy;
    action_e act;
    int pick;
    int items;

    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    hold_req = 1'b0;
    none = '{default: '0};
    rst_ni = 1'b0;
    valid_i = 1'b0;
    action_i = ACT_NONE;
    entry_index_i = '0;
    in_pos_x_i = '0;
    in_pos_y_i = '0;
    in_vel_x_i = '0;
    in_vel_y_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_FIELD_W;
    cfg_data_i = '0;
    cfg_reg = '{1024, 768, 131072, 6554, 10, 250, 200, 64};
    for (int i = 0; i < 64; i++) begin
      st_px[i] = 0; st_py[i] = 0; st_vx[i] = 0; st_vy[i] = 0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: four entries take part in a step
    vals = '{1024, 768, 131072, 6554, 10, 250, 200, 4};
    write_regs(vals);
    tab.push_back(row(ACT_WRITE, 0, 100 * PX, 100 * PX, PX, 0, 1));
    tab.push_back(row(ACT_WRITE, 1, 102 * PX, 101 * PX, 0, PX, 1));
    // same position as entry 0: skipped as a neighbor
    tab.push_back(row(ACT_WRITE, 2, 100 * PX, 100 * PX, -PX, -PX, 1));
    tab.push_back(row(ACT_WRITE, 3, -5 * PX, 2000 * PX, S_MAX, S_MIN, 1));
    tab.push_back(row(ACT_WRITE, 63, S_MAX, S_MIN, 0, 0, 1));
    tab.push_back(row(ACT_READ, 63, S_MAX, S_MIN, 0, 0, 1));
    tab.push_back(row(ACT_READ, 3, -5 * PX, 2000 * PX, S_MAX, S_MIN, 1));
    tab.push_back(row(ACT_NONE, 5, 0, 0, 0, 0, 1));
    tab.push_back(row(ACT_STEP, 0, 0, 0, 0, 0, 0));
    tab.push_back(row(ACT_STEP, 1, 0, 0, 0, 0, 0));
    tab.push_back(row(ACT_STEP, 2, 0, 0, 0, 0, 0));
    tab.push_back(row(ACT_STEP, 3, 0, 0, 0, 0, 0));
    tab.push_back(row(ACT_STEP, 63, 0, 0, 0, 0, 0));
    tab.push_back(row(ACT_READ, 0, 0, 0, 0, 0, 0));
    tab.push_back(row(ACT_WRITE, 5, 0, 0, 0, 0, 1));
    tab.push_back(row(ACT_STEP, 5, 0, 0, 0, 0, 0));
    tab.push_back(row(ACT_STEP, 3, 0, 0, 0, 0, 0));
    tab.push_back(row(ACT_READ, 5, 0, 0, 0, 0, 0));
    foreach (tab[i])
      send(tab[i].act, tab[i].idx, tab[i].px, tab[i].py, tab[i].vx, tab[i].vy,
           tab[i].typed, tab[i].want);

    // populate the whole store before wider steps
    for (int i = 0; i < 64; i++) begin
      rand_boid(px, py, vx, vy);
      send(ACT_WRITE, i[5:0], px, py, vx, vy, 0, none);
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin
          vals = '{1024, 768, 131072, 6554, 10, 250, 200, 16};
          items = 150;
        end
        1: begin
          vals = '{1, 1, 0, 0, 0, 0, 0, 0};
          items = 80;
        end
        2: begin
          vals = '{65535, 65535, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 4095, 4095, 4095, 12};
          items = 100;
        end
        3: begin
          vals = '{$urandom_range(1, 500), $urandom_range(1, 500), $urandom,
                   $urandom_range(0, 20000), $urandom_range(0, 60),
                   $urandom_range(0, 300), $urandom_range(0, 300), 127};
          items = 25;
        end
        default: begin
          vals = '{$urandom_range(1, 65535), $urandom_range(1, 65535),
                   $urandom_range(0, 8 * 65536), $urandom_range(0, 65536),
                   $urandom_range(0, 80), $urandom_range(0, 300),
                   $urandom_range(0, 300), $urandom_range(1, 20)};
          items = 160;
        end
      endcase
      write_regs(vals);
      if (p == 0) hold_req = 1'b1;
      for (int k = 0; k < items; k++) begin
        if (p == 4 && k == 60) settle();
        pick = $urandom_range(0, 99);
        act = pick < 45 ? ACT_STEP : pick < 80 ? ACT_WRITE : pick < 95 ? ACT_READ : ACT_NONE;
        rand_boid(px, py, vx, vy);
        send(act, 6'($urandom_range(0, 63)), px, py, vx, vy, 0, none);
      end
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
